>>> rtl/core/polyline_hit_test_bbox_core_macros.svh
// Assertion macros shared by the polyline hit test core.
// No dependencies; included by the controller and the datapath.
`ifndef POLYLINE_HIT_TEST_BBOX_CORE_MACROS_SVH
`define POLYLINE_HIT_TEST_BBOX_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLHB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLHB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/plhb_pkg.sv
// Package for the polyline hit test core: opcodes, register indexes,
// reset values and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plhb_pkg;

    localparam int TOL_W  = 12;
    localparam int TOL2_W = 24;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [0:0] REG_HIT_TOLERANCE = 1'd0;
    localparam logic [0:0] REG_BOX_MARGIN    = 1'd1;

    localparam logic [TOL_W-1:0] TOL_RESET    = 12'd128;
    localparam logic [TOL_W-1:0] MARGIN_RESET = 12'd128;

    typedef struct packed {
        logic accept;
        logic exec;
        logic rd_fire;
        logic rd_first;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_query;
        logic few_points;
        logic rd_last;
        logic pipe_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/core/plhb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module plhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/core/plhb_ctrl.sv
// Controller for the polyline hit test core: item handshake, vertex walk
// sequencing and output register valid. Depends on plhb_pkg and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "polyline_hit_test_bbox_core_macros.svh"

module plhb_ctrl
    import plhb_pkg::*;
#(
    parameter int CNT_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_dp_stat         i_stat,
    output t_ctrl_cmd             o_cmd,
    output logic      [CNT_W-1:0] o_rd_addr
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_rd_addr, n_rd_addr;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state   = r_state;
        n_rd_addr = r_rd_addr;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_rd_addr  = '0;
                if (i_stat.is_query && !i_stat.few_points) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_READ: begin
                o_cmd.rd_fire  = 1'b1;
                o_cmd.rd_first = (r_rd_addr == '0);
                if (i_stat.rd_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_addr = r_rd_addr + CNT_W'(1);
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_addr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_addr   <= n_rd_addr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rd_addr   = r_rd_addr;

    `PLHB_ASSERT(a_no_walk_short, i_clk, i_rst_n, o_cmd.rd_fire |-> !i_stat.few_points, "vertex read with fewer than two points")
    `PLHB_ASSERT(a_finish_drained, i_clk, i_rst_n, (r_state == S_FINISH) |-> !i_stat.pipe_busy, "result formed while segment pipe busy")
    `PLHB_ASSERT_NEXT(a_load_to_idle, i_clk, i_rst_n, o_cmd.load_out, (r_state == S_IDLE) && r_out_valid, "output load did not return to idle")

endmodule

`default_nettype wire

>>> rtl/core/plhb_dp.sv
// Datapath for the polyline hit test core: vertex store, running box,
// segment distance pipeline and result register. Depends on plhb_pkg,
// plhb_ram and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "polyline_hit_test_bbox_core_macros.svh"

module plhb_dp
    import plhb_pkg::*;
#(
    parameter int MAX_POINTS = 128,
    parameter int COORD_BITS = 16,
    localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [0:0]                   i_cfg_index,
    input  wire logic [TOL_W-1:0]             i_cfg_wdata,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic signed [COORD_BITS-1:0] i_coord_x,
    input  wire logic signed [COORD_BITS-1:0] i_coord_y,
    input  wire t_ctrl_cmd                    i_cmd,
    input  wire logic [CNT_W-1:0]             i_rd_addr,
    output t_dp_stat                          o_stat,
    output logic                              o_hit,
    output logic                              o_dropped,
    output logic [CNT_W-1:0]                  o_point_count,
    output logic                              o_box_valid,
    output logic signed [COORD_BITS:0]        o_box_min_x,
    output logic signed [COORD_BITS:0]        o_box_min_y,
    output logic signed [COORD_BITS:0]        o_box_max_x,
    output logic signed [COORD_BITS:0]        o_box_max_y
);

    localparam int CW   = COORD_BITS;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * CW + 2;
    localparam int SW   = 2 * CW + 3;
    localparam int QW   = 2 * CW + 2;
    localparam int HW   = CW + 1;
    localparam int CMW  = 2 * HW;
    localparam int NW   = (QW > TOL2_W) ? QW : TOL2_W;
    localparam int LW   = 4 * HW;
    localparam int RW   = TOL2_W + 2 * HW;
    localparam int CMPW = (LW > RW) ? LW : RW;
    localparam int BXW  = ((CW > TOL_W) ? CW : TOL_W) + 2;
    localparam int NSTG = 6;

    function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return PW'(a) * PW'(b);
    endfunction

    // item and configuration
    logic [1:0]             r_op;
    logic signed [CW-1:0]   r_px, r_py;
    logic [TOL_W-1:0]       r_tol, r_margin;
    logic [TOL2_W-1:0]      r_tol2;

    // polyline state
    logic [CNT_W-1:0]       r_count;
    logic signed [CW-1:0]   r_min_x, r_min_y, r_max_x, r_max_y;
    logic                   r_dropped, r_hit;
    logic                   w_full;

    // vertex store
    logic                   w_wr_en;
    logic [2*CW-1:0]        w_rd_data;
    logic signed [CW-1:0]   w_rd_x, w_rd_y;
    logic                   r_rd_pend, r_rd_first;
    logic signed [CW-1:0]   r_p1x, r_p1y;

    // segment pipe
    logic [NSTG-1:0]        r_vld;
    logic signed [DW-1:0]   r_s1_wx, r_s1_wy, r_s1_vx, r_s1_vy, r_s1_ux, r_s1_uy;
    logic signed [PW-1:0]   r_s2_wxvx, r_s2_wyvy, r_s2_vxvx, r_s2_vyvy, r_s2_wxvy, r_s2_wyvx;
    logic signed [PW-1:0]   r_s2_wxwx, r_s2_wywy, r_s2_uxux, r_s2_uyuy;
    logic signed [SW-1:0]   r_s3_c1, r_s3_cross;
    logic [QW-1:0]          r_s3_c2, r_s3_dp1, r_s3_dp2;
    logic [SW-1:0]          w_cross_neg;
    logic [CMW-1:0]         r_s4_cm;
    logic [QW-1:0]          r_s4_c2;
    logic [2:0]             r_s4_flg, r_s5_flg, r_s6_flg;
    logic                   r_s4_near1, r_s4_near2;
    logic                   r_s5_near1, r_s5_near2, r_s6_near1, r_s6_near2;
    logic [2*HW-1:0]        r_s5_hh, r_s5_hl, r_s5_ll;
    logic [TOL2_W+HW-1:0]   r_s5_th, r_s5_tl;
    logic [CMPW-1:0]        r_s6_lhs, r_s6_rhs;
    logic                   w_seg_hit;
    logic [BXW-1:0]         w_bx_min_x, w_bx_min_y, w_bx_max_x, w_bx_max_y;

    assign w_full = (r_count == CNT_W'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= TOL_RESET;
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_HIT_TOLERANCE: r_tol    <= i_cfg_wdata;
                REG_BOX_MARGIN:    r_margin <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tol2 <= TOL2_W'(r_tol) * TOL2_W'(r_tol);
        if (i_cmd.accept) begin
            r_op <= i_opcode;
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
    end

    // clear and append
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_min_x   <= '0;
            r_min_y   <= '0;
            r_max_x   <= '0;
            r_max_y   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.accept) begin
            r_dropped <= 1'b0;
        end else if (i_cmd.exec) begin
            if (r_op == OP_CLEAR) begin
                r_count <= '0;
                r_min_x <= '0;
                r_min_y <= '0;
                r_max_x <= '0;
                r_max_y <= '0;
            end else if (r_op == OP_APPEND) begin
                if (w_full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                    if (r_count == '0) begin
                        r_min_x <= r_px;
                        r_max_x <= r_px;
                        r_min_y <= r_py;
                        r_max_y <= r_py;
                    end else begin
                        if (r_px < r_min_x) r_min_x <= r_px;
                        if (r_px > r_max_x) r_max_x <= r_px;
                        if (r_py < r_min_y) r_min_y <= r_py;
                        if (r_py > r_max_y) r_max_y <= r_py;
                    end
                end
            end
        end
    end

    assign w_wr_en = i_cmd.exec && (r_op == OP_APPEND) && !w_full;

    plhb_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_POINTS)
    ) u_vtx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data ({r_px, r_py}),
        .i_rd_en   (i_cmd.rd_fire),
        .i_rd_addr (i_rd_addr[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_x = w_rd_data[2*CW-1:CW];
    assign w_rd_y = w_rd_data[CW-1:0];

    // segment pipe control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_vld     <= '0;
        end else begin
            r_rd_pend <= i_cmd.rd_fire;
            r_vld     <= {r_vld[NSTG-2:0], r_rd_pend && !r_rd_first};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= i_cmd.rd_first;
        if (r_rd_pend) begin
            r_p1x <= w_rd_x;
            r_p1y <= w_rd_y;
        end
        // s1: differences against p1 and p2
        r_s1_wx <= DW'(r_px) - DW'(r_p1x);
        r_s1_wy <= DW'(r_py) - DW'(r_p1y);
        r_s1_vx <= DW'(w_rd_x) - DW'(r_p1x);
        r_s1_vy <= DW'(w_rd_y) - DW'(r_p1y);
        r_s1_ux <= DW'(r_px) - DW'(w_rd_x);
        r_s1_uy <= DW'(r_py) - DW'(w_rd_y);
        // s2: products
        r_s2_wxvx <= smul(r_s1_wx, r_s1_vx);
        r_s2_wyvy <= smul(r_s1_wy, r_s1_vy);
        r_s2_vxvx <= smul(r_s1_vx, r_s1_vx);
        r_s2_vyvy <= smul(r_s1_vy, r_s1_vy);
        r_s2_wxvy <= smul(r_s1_wx, r_s1_vy);
        r_s2_wyvx <= smul(r_s1_wy, r_s1_vx);
        r_s2_wxwx <= smul(r_s1_wx, r_s1_wx);
        r_s2_wywy <= smul(r_s1_wy, r_s1_wy);
        r_s2_uxux <= smul(r_s1_ux, r_s1_ux);
        r_s2_uyuy <= smul(r_s1_uy, r_s1_uy);
        // s3: dot, length, cross, endpoint distances
        r_s3_c1    <= SW'(r_s2_wxvx) + SW'(r_s2_wyvy);
        r_s3_cross <= SW'(r_s2_wxvy) - SW'(r_s2_wyvx);
        r_s3_c2    <= QW'(r_s2_vxvx[PW-2:0]) + QW'(r_s2_vyvy[PW-2:0]);
        r_s3_dp1   <= QW'(r_s2_wxwx[PW-2:0]) + QW'(r_s2_wywy[PW-2:0]);
        r_s3_dp2   <= QW'(r_s2_uxux[PW-2:0]) + QW'(r_s2_uyuy[PW-2:0]);
        // s4: classify, endpoint checks, |cross|
        r_s4_cm    <= r_s3_cross[SW-1] ? w_cross_neg[CMW-1:0] : r_s3_cross[CMW-1:0];
        r_s4_c2    <= r_s3_c2;
        r_s4_flg   <= {r_s3_c1[SW-1] || (r_s3_c1 == '0),
                       $signed({1'b0, r_s3_c2}) <= r_s3_c1,
                       1'b0};
        r_s4_near1 <= NW'(r_s3_dp1) <= NW'(r_tol2);
        r_s4_near2 <= NW'(r_s3_dp2) <= NW'(r_tol2);
        // s5: partial products of cross^2 and tol^2 * |v|^2
        r_s5_hh    <= (2*HW)'(r_s4_cm[CMW-1:HW]) * (2*HW)'(r_s4_cm[CMW-1:HW]);
        r_s5_hl    <= (2*HW)'(r_s4_cm[CMW-1:HW]) * (2*HW)'(r_s4_cm[HW-1:0]);
        r_s5_ll    <= (2*HW)'(r_s4_cm[HW-1:0]) * (2*HW)'(r_s4_cm[HW-1:0]);
        r_s5_th    <= (TOL2_W+HW)'(r_tol2) * (TOL2_W+HW)'(r_s4_c2[QW-1:HW]);
        r_s5_tl    <= (TOL2_W+HW)'(r_tol2) * (TOL2_W+HW)'(r_s4_c2[HW-1:0]);
        r_s5_flg   <= r_s4_flg;
        r_s5_near1 <= r_s4_near1;
        r_s5_near2 <= r_s4_near2;
        // s6: recombine
        r_s6_lhs   <= (CMPW'(r_s5_hh) << (2 * HW)) + (CMPW'(r_s5_hl) << (HW + 1))
                      + CMPW'(r_s5_ll);
        r_s6_rhs   <= (CMPW'(r_s5_th) << HW) + CMPW'(r_s5_tl);
        r_s6_flg   <= r_s5_flg;
        r_s6_near1 <= r_s5_near1;
        r_s6_near2 <= r_s5_near2;
    end

    assign w_cross_neg = '0 - r_s3_cross;

    // flg[2]: projection at or before p1, flg[1]: at or past p2
    always_comb begin
        if (r_s6_flg[2]) begin
            w_seg_hit = r_s6_near1;
        end else if (r_s6_flg[1]) begin
            w_seg_hit = r_s6_near2;
        end else begin
            w_seg_hit = (r_s6_lhs <= r_s6_rhs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.accept) begin
            r_hit <= 1'b0;
        end else if (r_vld[NSTG-1] && w_seg_hit) begin
            r_hit <= 1'b1;
        end
    end

    // result register
    assign w_bx_min_x = BXW'(r_min_x) - BXW'(r_margin);
    assign w_bx_min_y = BXW'(r_min_y) - BXW'(r_margin);
    assign w_bx_max_x = BXW'(r_max_x) + BXW'(r_margin);
    assign w_bx_max_y = BXW'(r_max_y) + BXW'(r_margin);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_hit         <= r_hit;
            o_dropped     <= r_dropped;
            o_point_count <= r_count;
            o_box_valid   <= (r_count != '0);
            if (r_count != '0) begin
                o_box_min_x <= w_bx_min_x[CW:0];
                o_box_min_y <= w_bx_min_y[CW:0];
                o_box_max_x <= w_bx_max_x[CW:0];
                o_box_max_y <= w_bx_max_y[CW:0];
            end else begin
                o_box_min_x <= '0;
                o_box_min_y <= '0;
                o_box_max_x <= '0;
                o_box_max_y <= '0;
            end
        end
    end

    assign o_stat.is_query   = (r_op == OP_QUERY);
    assign o_stat.few_points = (r_count < CNT_W'(2));
    assign o_stat.rd_last    = (i_rd_addr == (r_count - CNT_W'(1)));
    assign o_stat.pipe_busy  = r_rd_pend || (|r_vld);

    `PLHB_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_POINTS), "vertex count above store depth")
    `PLHB_ASSERT(a_drop_when_full, i_clk, i_rst_n, r_dropped |-> w_full, "append dropped with room in store")
    `PLHB_ASSERT(a_hit_only_query, i_clk, i_rst_n, r_hit |-> (r_op == OP_QUERY), "hit set for a non-query item")

endmodule

`default_nettype wire

>>> rtl/core/polyline_hit_test_bbox_core.sv
// Polyline hit test core, top level: controller plus datapath.
// Depends on plhb_pkg, plhb_ctrl, plhb_dp and plhb_ram.
//
// Items are clear, append vertex, hit query and no-op; each gives one result
// carrying the point count and the bounding box widened by the margin. In a
// query over N stored vertices (N >= 2), the vertex store's single read port
// feeds one vertex a cycle into a 6-stage segment distance pipe, which then
// drains before the result is formed. A query over fewer than two vertices
// skips the vertex walk. A new item is accepted while the previous result
// still waits on the output.
`timescale 1ns / 1ps
`default_nettype none

module polyline_hit_test_bbox_core
    import plhb_pkg::*;
#(
    parameter int MAX_POINTS = 128,
    parameter int COORD_BITS = 16,
    localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [0:0]                   i_cfg_index,
    input  wire logic [TOL_W-1:0]             i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_opcode,
    input  wire logic signed [COORD_BITS-1:0] i_coord_x,
    input  wire logic signed [COORD_BITS-1:0] i_coord_y,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_hit,
    output logic                              o_dropped,
    output logic [CNT_W-1:0]                  o_point_count,
    output logic                              o_box_valid,
    output logic signed [COORD_BITS:0]        o_box_min_x,
    output logic signed [COORD_BITS:0]        o_box_min_y,
    output logic signed [COORD_BITS:0]        o_box_max_x,
    output logic signed [COORD_BITS:0]        o_box_max_y
);

    t_ctrl_cmd        w_cmd;
    t_dp_stat         w_stat;
    logic [CNT_W-1:0] w_rd_addr;

    plhb_ctrl #(
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr)
    );

    plhb_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_opcode      (i_opcode),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_cmd         (w_cmd),
        .i_rd_addr     (w_rd_addr),
        .o_stat        (w_stat),
        .o_hit         (o_hit),
        .o_dropped     (o_dropped),
        .o_point_count (o_point_count),
        .o_box_valid   (o_box_valid),
        .o_box_min_x   (o_box_min_x),
        .o_box_min_y   (o_box_min_y),
        .o_box_max_x   (o_box_max_x),
        .o_box_max_y   (o_box_max_y)
    );

endmodule

`default_nettype wire
